// ===== rtl/ple_pkg.sv =====
// Shared types, operation codes and controller/datapath interface for the positional list engine.
package ple_pkg;

    // Field widths of the item formats
    localparam int FUNC_W       = 3;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 7;
    localparam int LEN_W        = 7;
    localparam int CAPACITY_DEF = 64;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_PREPEND = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_INSERT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DELETE  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic [LEN_W-1:0]          length;
        logic                      error;
    } t_out_item;

    // Read address source for the element store
    typedef enum logic [1:0] {
        RD_POS,
        RD_PREV,
        RD_NEXT
    } t_rd_sel;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load;
        logic    decode;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    move;
        logic    write_new;
        logic    shrink;
        logic    out_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic err;
        logic is_del;
        logic is_read;
        logic at_end;
    } t_sts;

endpackage

// ===== rtl/ple_ctrl.sv =====
// Controller state machine sequencing decode, element moves, store update and result hand-off.
module ple_ctrl import ple_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MOVE_RD,
        S_MOVE_WR,
        S_WRITE,
        S_SHRINK,
        S_READ_WAIT,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // Decide next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & i_stall;
        o_cmd       = '0;
        o_cmd.rd_sel = RD_POS;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                if (i_sts.err) begin
                    n_state = S_DONE;
                end else if (i_sts.is_read) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_POS;
                    n_state      = S_READ_WAIT;
                end else begin
                    n_state = S_MOVE_RD;
                end
            end
            S_MOVE_RD: begin
                if (i_sts.at_end) begin
                    n_state = i_sts.is_del ? S_SHRINK : S_WRITE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = i_sts.is_del ? RD_NEXT : RD_PREV;
                    n_state      = S_MOVE_WR;
                end
            end
            S_MOVE_WR: begin
                o_cmd.move = 1'b1;
                n_state    = S_MOVE_RD;
            end
            S_WRITE: begin
                o_cmd.write_new = 1'b1;
                n_state         = S_DONE;
            end
            S_SHRINK: begin
                o_cmd.shrink = 1'b1;
                n_state      = S_DONE;
            end
            S_READ_WAIT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                // Hand off once the output register is free
                if (!r_out_valid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ===== rtl/ple_datapath.sv =====
// Datapath: element store, length counter, operand registers, range checks and result register.
module ple_datapath import ple_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output t_out_item o_item
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [VALUE_W-1:0] r_mem [CAPACITY];

    logic [FUNC_W-1:0]  r_func;
    logic [VALUE_W-1:0] r_value;
    logic [POS_W-1:0]   r_pos;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_idx;
    logic [AW-1:0]      r_tgt;
    logic               r_err;
    logic [VALUE_W-1:0] r_rdata;
    t_out_item          r_out;

    logic [EW-1:0]      pos_e;
    logic [EW-1:0]      cnt_e;
    logic               full;
    logic               pos0;
    logic               dec_err;
    logic [AW-1:0]      pos_idx;
    logic [AW-1:0]      n_tgt;
    logic [AW-1:0]      rd_addr;
    logic               is_del;
    logic               is_read;

    // Range and capacity checks on the latched item
    always_comb begin
        pos_e   = EW'(r_pos);
        cnt_e   = EW'(r_count);
        full    = (r_count == CW'(CAPACITY));
        pos0    = (r_pos == '0);
        pos_idx = AW'(r_pos - POS_W'(1));
        is_del  = (r_func == FUNC_DELETE);
        is_read = (r_func == FUNC_READ);
        case (r_func)
            FUNC_PREPEND: begin
                dec_err = full;
                n_tgt   = '0;
            end
            FUNC_APPEND: begin
                dec_err = full;
                n_tgt   = r_count[AW-1:0];
            end
            FUNC_INSERT: begin
                dec_err = full || pos0 || (pos_e > cnt_e + EW'(1));
                n_tgt   = pos_idx;
            end
            FUNC_DELETE: begin
                dec_err = pos0 || (pos_e > cnt_e);
                n_tgt   = pos_idx;
            end
            FUNC_READ: begin
                dec_err = pos0 || (pos_e > cnt_e);
                n_tgt   = pos_idx;
            end
            default: begin
                dec_err = 1'b1;
                n_tgt   = '0;
            end
        endcase
    end

    // Report status to the controller
    always_comb begin
        o_sts.err     = dec_err;
        o_sts.is_del  = is_del;
        o_sts.is_read = is_read;
        if (is_del) begin
            o_sts.at_end = (CW'(r_idx) + CW'(1) == r_count);
        end else begin
            o_sts.at_end = (r_idx == r_tgt);
        end
    end

    // Select the store read address
    always_comb begin
        case (i_cmd.rd_sel)
            RD_POS:  rd_addr = pos_idx;
            RD_PREV: rd_addr = r_idx - AW'(1);
            RD_NEXT: rd_addr = r_idx + AW'(1);
            default: rd_addr = pos_idx;
        endcase
    end

    // Element store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.move) begin
            r_mem[r_idx] <= r_rdata;
        end else if (i_cmd.write_new) begin
            r_mem[r_tgt] <= r_value;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Latch the item, decode the operation, step the move index and load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_item.func;
            r_value <= i_item.value;
            r_pos   <= i_item.position;
        end
        if (i_cmd.decode) begin
            r_err <= dec_err;
            r_tgt <= n_tgt;
            r_idx <= is_del ? n_tgt : r_count[AW-1:0];
        end else if (i_cmd.move) begin
            r_idx <= is_del ? (r_idx + AW'(1)) : (r_idx - AW'(1));
        end
        if (i_cmd.out_load) begin
            r_out.read_value <= (is_read && !r_err) ? r_rdata : '0;
            r_out.length     <= LEN_W'(r_count);
            r_out.error      <= r_err;
        end
    end

    // Track the number of held elements
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.write_new) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.shrink) begin
            r_count <= r_count - CW'(1);
        end
    end

    assign o_item = r_out;

endmodule

// ===== rtl/positional_list_engine_top.sv =====
// Top level of the positional list engine: controller and datapath joined by command and status.
//
// Usage:
//   Input items (func, value, position) enter on i_valid/o_stall; one result item
//   (read_value, length, error) leaves on o_valid/i_stall for every input item.
//   The block works on one item at a time. An item is taken only while the
//   controller is idle; its result is placed in an output register, so the next
//   item can be taken while that result still waits for the receiver.
//   An item runs from decode to done: a rejected item goes straight to done, a
//   read waits for the store read, and an insert, prepend, append or delete moves
//   its elements one by one (each move is a store read followed by a store write,
//   since the store has one registered read port and one write port).
//   Append and deleting the last element move nothing; prepend on a full-ish
//   list moves up to CAPACITY-1 elements.
//   Reset empties the list and clears o_valid; store contents are not
//   cleared, as positions beyond the length are never read.
//   While the receiver stalls, the result holds and a finished next item waits
//   in its final state until the output register frees up.
module positional_list_engine_top import ple_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    t_cmd cmd;
    t_sts sts;

    ple_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ple_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_item  (o_item)
    );

endmodule

// ===== test/positional_list_engine_top_test.sv =====
// Testbench for the positional list engine: directed and random list operations checked against a predictor.
`timescale 1ns / 100ps

module positional_list_engine_top_test;
    import ple_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = FUNC_READ + 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = '1;
    localparam int unsigned ITEM_COUNT = 1700;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_COMB,
        STALL_HEAVY
    } t_stall_kind;

    // Predicts each result from a private copy of the list and checks results in order
    class list_scoreboard;
        logic signed [VALUE_W-1:0] elems[$];
        t_out_item pending_results[$];
        int fails;
        int results_seen;
        int rejects;
        int full_hits;
        int peak_len;
        int op_count[8];

        task report(string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            fails++;
        endtask

        // Apply one accepted item to the list and queue its result
        function void note_input(t_in_item it);
            t_out_item res;
            int unsigned n;
            int unsigned p;
            n = elems.size();
            p = it.position;
            res = '0;
            if (n >= CAPACITY_DEF) full_hits++;
            case (it.func)
                FUNC_PREPEND, FUNC_APPEND, FUNC_INSERT: begin
                    if (it.func == FUNC_PREPEND) p = 1;
                    else if (it.func == FUNC_APPEND) p = n + 1;
                    if (n >= CAPACITY_DEF || p == 0 || p > n + 1) res.error = 1'b1;
                    else elems.insert(p - 1, it.value);
                end
                FUNC_DELETE: begin
                    if (p == 0 || p > n) res.error = 1'b1;
                    else elems.delete(p - 1);
                end
                FUNC_READ: begin
                    if (p == 0 || p > n) res.error = 1'b1;
                    else res.read_value = elems[p - 1];
                end
                default: res.error = 1'b1;
            endcase
            res.length = LEN_W'(elems.size());
            if (res.error) rejects++;
            if (elems.size() > peak_len) peak_len = elems.size();
            op_count[it.func]++;
            pending_results.push_back(res);
        endfunction

        // Compare one delivered result with the oldest prediction
        task check_result(t_out_item got);
            t_out_item want;
            results_seen++;
            if (pending_results.size() == 0) begin
                report($sformatf("result with nothing pending: %p", got));
                return;
            end
            want = pending_results.pop_front();
            if (got.read_value !== want.read_value)
                report($sformatf("read_value %0d, predicted %0d", got.read_value,
                                 want.read_value));
            if (got.length !== want.length)
                report($sformatf("length %0d, predicted %0d", got.length, want.length));
            if (got.error !== want.error)
                report($sformatf("error %b, predicted %b", got.error, want.error));
        endtask
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_item;

    list_scoreboard sb;
    int unsigned burst_left = 0;
    int unsigned cyc = 0;
    t_stall_kind stall_mode = STALL_NONE;
    bit growing = 1'b1;

    positional_list_engine_top #(
        .CAPACITY (CAPACITY_DEF)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Run guard
    initial begin
        #10_000_000;
        $display("TIMEOUT: results still outstanding at %0t ns", $time);
        $display("Test completed with failures");
        $finish;
    end

    // Receiver stall pattern, switching to a random style whenever the low six bits of the cycle counter are zero
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc[5:0] == 6'd0) stall_mode <= t_stall_kind'($urandom_range(0, 3));
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            STALL_COMB:  i_stall <= (cyc[2:0] < 3'd3);
            default:     i_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Check every delivered result
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_item);
    end

    // Offer one item in the current burst, idling between bursts
    task drive(t_in_item it);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 40);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 3);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(it);
    endtask

    // Pick one random item, mostly well-formed for the current list length
    function automatic t_in_item gen_item(bit grow, int unsigned n);
        t_in_item it;
        int unsigned pick;
        it.value = $urandom;
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0: it.value = 32'sh7FFF_FFFF;
                1: it.value = 32'sh8000_0000;
                2: it.value = 32'sh0000_0000;
                default: it.value = 32'shFFFF_FFFF;
            endcase
        end
        it.func = FUNC_INSERT;
        it.position = POS_W'($urandom_range(1, n + 1));
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            // noise: any code, any position
            it.func = FUNC_W'($urandom);
            it.position = $urandom_range(0, 1) ? POS_W'($urandom_range(0, CAPACITY_DEF + 1))
                                               : POS_W'($urandom);
        end else if (pick < 10) begin
            // just past the end, or position zero
            it.func = FUNC_W'($urandom_range(FUNC_INSERT, FUNC_READ));
            if ($urandom_range(0, 2) == 0) it.position = '0;
            else it.position = POS_W'((it.func == FUNC_INSERT) ? n + 2 : n + 1);
        end else begin
            if (grow) begin
                if (pick < 35) it.func = FUNC_APPEND;
                else if (pick < 55) it.func = FUNC_PREPEND;
                else if (pick < 82) it.func = FUNC_INSERT;
                else if (pick < 92) it.func = FUNC_READ;
                else it.func = FUNC_DELETE;
            end else begin
                if (pick < 60) it.func = FUNC_DELETE;
                else if (pick < 80) it.func = FUNC_READ;
                else if (pick < 90) it.func = FUNC_INSERT;
                else it.func = FUNC_APPEND;
            end
            if (it.func == FUNC_READ || it.func == FUNC_DELETE)
                it.position = POS_W'((n == 0) ? 1 : $urandom_range(1, n));
        end
        return it;
    endfunction

    initial begin
        int unsigned n;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty list, bounds, extremes, every operation
        drive(t_in_item'{FUNC_READ,    32'sd0, 7'd1});
        drive(t_in_item'{FUNC_DELETE,  32'sd0, 7'd1});
        drive(t_in_item'{FUNC_INSERT,  32'sd5, 7'd0});
        drive(t_in_item'{FUNC_INSERT,  32'sd5, 7'd2});
        drive(t_in_item'{FUNC_INSERT,  32'sh7FFF_FFFF, 7'd1});
        drive(t_in_item'{FUNC_PREPEND, 32'sh8000_0000, 7'd0});
        drive(t_in_item'{FUNC_APPEND,  32'shFFFF_FFFF, 7'd127});
        drive(t_in_item'{FUNC_INSERT,  32'sd0, 7'd4});
        drive(t_in_item'{FUNC_INSERT,  32'sh5555_5555, 7'd2});
        drive(t_in_item'{FUNC_READ,    32'sd0, 7'd0});
        drive(t_in_item'{FUNC_READ,    32'sd0, 7'd1});
        drive(t_in_item'{FUNC_READ,    32'sd0, 7'd5});
        drive(t_in_item'{FUNC_READ,    32'sd0, 7'd6});
        drive(t_in_item'{FUNC_DELETE,  32'sd0, 7'd6});
        drive(t_in_item'{FUNC_DELETE,  32'sd0, 7'd3});
        drive(t_in_item'{FUNC_DELETE,  32'sd0, 7'd4});
        drive(t_in_item'{FUNC_DELETE,  32'sd0, 7'd1});
        for (int f = FUNC_SPARE_LO; f <= FUNC_SPARE_HI; f++)
            drive(t_in_item'{FUNC_W'(f), 32'sd7, 7'd1});
        // empty the list, then reuse it as a fresh one
        drive(t_in_item'{FUNC_DELETE,  32'sd0, 7'd1});
        drive(t_in_item'{FUNC_DELETE,  32'sd0, 7'd1});
        drive(t_in_item'{FUNC_APPEND,  32'shAAAA_AAAA, 7'd0});
        drive(t_in_item'{FUNC_READ,    32'sd0, 7'd1});
        drive(t_in_item'{FUNC_READ,    32'sd0, 7'd64});
        drive(t_in_item'{FUNC_DELETE,  32'sd0, 7'd65});

        // Random: alternate filling to capacity and draining to empty
        for (int k = 0; k < ITEM_COUNT; k++) begin
            n = sb.elems.size();
            if (growing && n >= CAPACITY_DEF && $urandom_range(0, 3) == 0) growing = 1'b0;
            else if (!growing && n == 0 && $urandom_range(0, 1) == 0) growing = 1'b1;
            else if ($urandom_range(0, 199) == 0) growing = !growing;
            drive(gen_item(growing, n));
        end
        i_valid <= 1'b0;

        // Drain, then watch for stray results
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * CAPACITY_DEF + 10) @(posedge i_clk);

        $display("Ran %0d items (prepend %0d, append %0d, insert %0d, delete %0d, read %0d)",
                 sb.results_seen, sb.op_count[FUNC_PREPEND], sb.op_count[FUNC_APPEND],
                 sb.op_count[FUNC_INSERT], sb.op_count[FUNC_DELETE], sb.op_count[FUNC_READ]);
        $display("%0d rejected; list peaked at %0d elements, %0d items arrived at capacity",
                 sb.rejects, sb.peak_len, sb.full_hits);
        if (sb.fails == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
